// ===== rtl/core/bpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants for the block pad/unpad engine.
// ----------------------------------------------------------------------------
package bpu_pkg;

	localparam int MAX_BLOCK_DEF = 32;
	localparam logic [5:0] BLK_LEN_RST = 6'd8;
	localparam int CFG_DW = 6;

	typedef enum logic [0:0] {
		REG_UNPAD_MODE   = 1'b0,
		REG_BLOCK_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_PARTIAL  = 2'd1,
		ST_BAD_PAD  = 2'd2,
		ST_PAD_DIFF = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RES,
		S_PAD_FILL,
		S_REL,
		S_P_CHK,
		S_CMP,
		S_STRIP
	} state_t;

endpackage

// ===== rtl/core/block_pad_unpad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_pad_unpad
// Byte-stream block padder (add) and unpadder (check and strip).
// ----------------------------------------------------------------------------
// Input words arrive on s_*: s_tdata is the byte, s_tlast marks end of stream
// (its byte is ignored). Results leave on m_*: m_tdata is the byte, m_tuser
// carries has_byte and status, m_tlast flags the final word of a stream.
// cfg_we/cfg_addr/cfg_wdata write unpad_mode (0) or block_length (1); any
// write restarts the stream. Block length is clamped to 1..MAX_BLOCK.
// In pad mode each byte is passed on through a result state, and end of
// stream emits the N pad words. Unpad mode stores a byte in the buffer; a
// byte that releases a held block waits while the block is streamed out of
// the buffer one byte a cycle while the output is not stalled, and is then
// stored. End of stream in unpad mode runs the pad checks, then emits the
// stripped block. Each result word is formed, then registered in the output
// register.
// Reset clears the mode to pad, length to 8, and the stream state; buffer
// contents are not cleared. While m_tready is low the output word holds and
// a sequencer with a word to emit stalls; s_tready is high only when idle.
// ----------------------------------------------------------------------------
module block_pad_unpad import bpu_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] out_byte
	output logic [2:0]        m_tuser,   // [0] has_byte, [2:1] status
	output logic              m_tlast,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int CW = $clog2(MAX_BLOCK + 1);
	localparam logic [6:0] MAX7 = 7'(MAX_BLOCK);

	logic unpad_q;
	logic [5:0] blk_len_q;
	logic [6:0] len_ext;
	logic [CW-1:0] len;

	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unpad_q   <= 1'b0;
			blk_len_q <= BLK_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_UNPAD_MODE:   unpad_q   <= cfg_wdata[0];
				REG_BLOCK_LENGTH: blk_len_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (blk_len_q == 6'd0) begin
			len_ext = 7'd1;
		end else if ({1'b0, blk_len_q} > MAX7) begin
			len_ext = MAX7;
		end else begin
			len_ext = {1'b0, blk_len_q};
		end
	end

	assign len = CW'(len_ext);

	bpu_mem #(
		.DEPTH (MAX_BLOCK),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bpu_seq #(
		.MAX_BLOCK (MAX_BLOCK),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.unpad     (unpad_q),
		.len       (len),
		.cfg_clr   (cfg_we),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

// ===== rtl/core/bpu_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpu_mem
// Block buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpu_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bpu_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpu_seq
// Sequencer: takes input words, drives the block buffer, emits result words
// through an output register.
// ----------------------------------------------------------------------------
module bpu_seq import bpu_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF,
	parameter int AW        = 5,
	parameter int CW        = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          unpad,
	input  logic [CW-1:0] len,
	input  logic          cfg_clr,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic [2:0]    m_tuser,
	output logic          m_tlast,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);

	state_t state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic pend_q, pend_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] rd_left_q, rd_left_d;
	logic [AW-1:0] rd_addr_q, rd_addr_d;
	logic memv_q, memv_d;
	logic [7:0] byte_q, byte_d;
	logic [7:0] p_q, p_d;
	logic [AW-1:0] chk_addr_q, chk_addr_d;
	logic [CW-1:0] chk_left_q, chk_left_d;
	logic [7:0] res_byte_q, res_byte_d;
	logic res_has_q, res_has_d;
	logic res_last_q, res_last_d;
	status_t res_st_q, res_st_d;

	logic ov_q;
	logic [7:0] ob_q;
	logic oh_q, ol_q;
	status_t os_q;

	logic out_free, push;
	logic [7:0] push_byte;
	logic push_has, push_last;
	status_t push_st;
	logic consume, issue;
	logic strip_go;
	logic [CW-1:0] strip_cnt;
	logic [CW-1:0] fill_inc;

	assign out_free = !ov_q || m_tready;
	assign fill_inc = fill_q + CW'(1);
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		pend_d     = pend_q;
		cnt_d      = cnt_q;
		rd_left_d  = rd_left_q;
		rd_addr_d  = rd_addr_q;
		memv_d     = memv_q;
		byte_d     = byte_q;
		p_d        = p_q;
		chk_addr_d = chk_addr_q;
		chk_left_d = chk_left_q;
		res_byte_d = res_byte_q;
		res_has_d  = res_has_q;
		res_last_d = res_last_q;
		res_st_d   = res_st_q;
		push       = 1'b0;
		push_byte  = 8'd0;
		push_has   = 1'b0;
		push_last  = 1'b0;
		push_st    = ST_OK;
		mem_we     = 1'b0;
		mem_waddr  = AW'(fill_q);
		mem_wdata  = s_tdata;
		mem_re     = 1'b0;
		mem_raddr  = rd_addr_q;
		consume    = 1'b0;
		issue      = 1'b0;
		strip_go   = 1'b0;
		strip_cnt  = '0;

		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (!unpad) begin
						if (!s_tlast) begin
							res_byte_d = s_tdata;
							res_has_d  = 1'b1;
							res_last_d = 1'b0;
							res_st_d   = ST_OK;
							fill_d     = (fill_inc == len) ? '0 : fill_inc;
							state_d    = S_RES;
						end else begin
							byte_d  = 8'(len - fill_q);
							cnt_d   = len - fill_q;
							fill_d  = '0;
							state_d = S_PAD_FILL;
						end
					end else if (!s_tlast) begin
						if (pend_q) begin
							// full block held: release it, the new byte goes in after
							byte_d    = s_tdata;
							cnt_d     = fill_q;
							rd_left_d = fill_q;
							rd_addr_d = '0;
							memv_d    = 1'b0;
							state_d   = S_REL;
						end else begin
							mem_we = 1'b1;
							fill_d = fill_inc;
							pend_d = (fill_inc >= len);
						end
					end else begin
						fill_d = '0;
						pend_d = 1'b0;
						if (!pend_q) begin
							res_byte_d = 8'd0;
							res_has_d  = 1'b0;
							res_last_d = 1'b1;
							res_st_d   = ST_PARTIAL;
							state_d    = S_RES;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = AW'(len - CW'(1));
							state_d   = S_P_CHK;
						end
					end
				end
			end
			S_RES: begin
				if (out_free) begin
					push      = 1'b1;
					push_byte = res_byte_q;
					push_has  = res_has_q;
					push_last = res_last_q;
					push_st   = res_st_q;
					state_d   = S_IDLE;
				end
			end
			S_PAD_FILL: begin
				if (out_free) begin
					push      = 1'b1;
					push_byte = byte_q;
					push_has  = 1'b1;
					push_last = (cnt_q == CW'(1));
					cnt_d     = cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			S_REL, S_STRIP: begin
				// one-deep prefetch: next read issues in the cycle the held data leaves
				consume = memv_q && out_free;
				issue   = (rd_left_q != '0) && (!memv_q || consume);
				mem_re  = issue;
				if (issue) begin
					rd_addr_d = rd_addr_q + AW'(1);
					rd_left_d = rd_left_q - CW'(1);
				end
				memv_d = issue || (memv_q && !consume);
				if (consume) begin
					push      = 1'b1;
					push_byte = mem_rdata;
					push_has  = 1'b1;
					push_last = (state_q == S_STRIP) && (cnt_q == CW'(1));
					cnt_d     = cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_d = S_IDLE;
						if (state_q == S_REL) begin
							mem_we    = 1'b1;
							mem_waddr = '0;
							mem_wdata = byte_q;
							fill_d    = CW'(1);
							pend_d    = (len == CW'(1));
						end
					end
				end
			end
			S_P_CHK: begin
				p_d = mem_rdata;
				if (mem_rdata == 8'd0 || mem_rdata > {{(8-CW){1'b0}}, len}) begin
					res_byte_d = 8'd0;
					res_has_d  = 1'b0;
					res_last_d = 1'b1;
					res_st_d   = ST_BAD_PAD;
					state_d    = S_RES;
				end else if (mem_rdata == 8'd1) begin
					strip_go  = 1'b1;
					strip_cnt = len - CW'(1);
				end else begin
					chk_left_d = CW'(mem_rdata) - CW'(1);
					chk_addr_d = AW'(len - CW'(2));
					mem_re     = 1'b1;
					mem_raddr  = AW'(len - CW'(2));
					state_d    = S_CMP;
				end
			end
			S_CMP: begin
				if (mem_rdata != p_q) begin
					res_byte_d = 8'd0;
					res_has_d  = 1'b0;
					res_last_d = 1'b1;
					res_st_d   = ST_PAD_DIFF;
					state_d    = S_RES;
				end else if (chk_left_q == CW'(1)) begin
					strip_go  = 1'b1;
					strip_cnt = len - CW'(p_q);
				end else begin
					chk_left_d = chk_left_q - CW'(1);
					chk_addr_d = chk_addr_q - AW'(1);
					mem_re     = 1'b1;
					mem_raddr  = chk_addr_q - AW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (strip_go) begin
			if (strip_cnt == '0) begin
				// block was all padding
				res_byte_d = 8'd0;
				res_has_d  = 1'b0;
				res_last_d = 1'b1;
				res_st_d   = ST_OK;
				state_d    = S_RES;
			end else begin
				cnt_d     = strip_cnt;
				rd_left_d = strip_cnt;
				rd_addr_d = '0;
				memv_d    = 1'b0;
				state_d   = S_STRIP;
			end
		end

		if (cfg_clr) begin
			fill_d = '0;
			pend_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			pend_q  <= 1'b0;
			memv_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			pend_q  <= pend_d;
			memv_q  <= memv_d;
			if (push) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_q      <= cnt_d;
		rd_left_q  <= rd_left_d;
		rd_addr_q  <= rd_addr_d;
		byte_q     <= byte_d;
		p_q        <= p_d;
		chk_addr_q <= chk_addr_d;
		chk_left_q <= chk_left_d;
		res_byte_q <= res_byte_d;
		res_has_q  <= res_has_d;
		res_last_q <= res_last_d;
		res_st_q   <= res_st_d;
		if (push) begin
			ob_q <= push_byte;
			oh_q <= push_has;
			ol_q <= push_last;
			os_q <= push_st;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = ob_q;
	assign m_tuser  = {os_q, oh_q};
	assign m_tlast  = ol_q;

	a_pend_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> fill_q == len) else $error("pending block not full");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len) else $error("fill count beyond block length");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && os_q != ST_OK) |-> (!oh_q && ol_q)) else $error("error word malformed");

	a_cmp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> chk_left_q != '0) else $error("compare count underflow");

	a_prefetch: assert property (@(posedge clk) disable iff (!arst_n)
		memv_q |-> (state_q == S_REL || state_q == S_STRIP))
		else $error("prefetch valid outside streaming");

endmodule

// ===== sim/tb_block_pad_unpad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_pad_unpad
// Self-checking bench for the block pad/unpad engine. A scoreboard object
// keeps its own copy of the mode, the block length and the held block, and
// works out the words each accepted input should produce. Every output word
// is compared with the oldest expected one. Directed streams cover the pad
// and unpad corner cases. Random phases follow: each writes the registers,
// including out-of-range lengths, and then sends mostly well-formed streams
// with some broken ones. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_block_pad_unpad;
	import bpu_pkg::*;

	localparam int SETTLE_CYCLES = 2 * MAX_BLOCK_DEF + 16;
	localparam int RANDOM_ITEMS  = 200;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last;
		status_t    status;
	} out_word_t;

	class pad_scoreboard;
		bit          unpad;
		logic [5:0]  len_reg;
		logic [7:0]  held[MAX_BLOCK_DEF];
		int          fill;
		bit          full;
		out_word_t   expected_words[$];
		int          errors;

		function new();
			unpad = 1'b0;
			len_reg = BLK_LEN_RST;
			fill = 0;
			full = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [5:0] val);
			if (idx == REG_UNPAD_MODE) begin
				unpad = val[0];
			end else begin
				len_reg = val;
			end
			fill = 0;
			full = 1'b0;
		endfunction

		function int blk_len();
			int l;
			l = int'(len_reg);
			if (l < 1)
				l = 1;
			if (l > MAX_BLOCK_DEF)
				l = MAX_BLOCK_DEF;
			return l;
		endfunction

		function void push(logic [7:0] b, logic has, logic tail, status_t st);
			out_word_t w;
			w.out_byte = b;
			w.has_byte = has;
			w.last = tail;
			w.status = st;
			expected_words.push_back(w);
		endfunction

		// works out the words caused by one accepted input
		function void note_input(logic [7:0] b, bit eos);
			int len, n, p, i;
			bit bad;
			len = blk_len();
			if (!unpad) begin
				if (!eos) begin
					push(b, 1'b1, 1'b0, ST_OK);
					fill = (fill + 1) % len;
				end else begin
					n = len - (fill % len);
					for (i = 0; i < n; i++)
						push(n[7:0], 1'b1, i == n - 1, ST_OK);
					fill = 0;
					full = 1'b0;
				end
				return;
			end
			if (!eos) begin
				// a new byte proves the held block was not the last one
				if (full) begin
					for (i = 0; i < fill; i++)
						push(held[i], 1'b1, 1'b0, ST_OK);
					fill = 0;
					full = 1'b0;
				end
				if (fill < MAX_BLOCK_DEF) begin
					held[fill] = b;
					fill++;
				end
				if (fill >= len)
					full = 1'b1;
				return;
			end
			if (!full || fill == 0) begin
				push(8'd0, 1'b0, 1'b1, ST_PARTIAL);
			end else begin
				p = int'(held[fill - 1]);
				if (p == 0 || p > fill) begin
					push(8'd0, 1'b0, 1'b1, ST_BAD_PAD);
				end else begin
					bad = 1'b0;
					for (i = 1; i < p; i++)
						if (held[fill - 1 - i] != 8'(p))
							bad = 1'b1;
					if (bad) begin
						push(8'd0, 1'b0, 1'b1, ST_PAD_DIFF);
					end else if (fill == p) begin
						push(8'd0, 1'b0, 1'b1, ST_OK);
					end else begin
						for (i = 0; i < fill - p; i++)
							push(held[i], 1'b1, i + 1 == fill - p, ST_OK);
					end
				end
			end
			fill = 0;
			full = 1'b0;
		endfunction

		function void check_word(logic [7:0] d, logic has, logic tail, logic [1:0] st);
			out_word_t e;
			if (expected_words.size() == 0) begin
				$error("unexpected word: out_byte %0d has_byte %0d last %0d status %0d",
					d, has, tail, st);
				errors++;
				return;
			end
			e = expected_words.pop_front();
			if (d !== e.out_byte) begin
				$error("out_byte: expected %0d, got %0d", e.out_byte, d);
				errors++;
			end
			if (has !== e.has_byte) begin
				$error("has_byte: expected %0d, got %0d", e.has_byte, has);
				errors++;
			end
			if (tail !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, tail);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = 8'd0;     // [7:0] data_byte
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [7:0]        m_tdata;            // [7:0] out_byte
	logic [2:0]        m_tuser;            // [0] has_byte, [2:1] status
	logic              m_tlast;
	logic              cfg_we = 1'b0;
	logic [0:0]        cfg_addr = 1'b0;
	logic [CFG_DW-1:0] cfg_wdata = '0;

	pad_scoreboard sb = new();
	bit calm = 1'b0;
	int sent = 0;

	block_pad_unpad dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, none in a calm phase
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// sink side: check at the rising edge, move tready at the falling edge
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_word(m_tdata, m_tuser[0], m_tlast, m_tuser[2:1]);
			@(negedge clk);
			if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				stall = pick_gap();
				m_tready = (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	task automatic send_word(logic [7:0] b, bit eos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = eos;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(b, eos);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(logic [7:0] q[$], bit close);
		foreach (q[i])
			send_word(q[i], 1'b0);
		if (close)
			send_word(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// wait out all expected words plus the engine's own busy time
	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [5:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(bit mode, logic [5:0] len);
		drain();
		// upper bits of the mode write are don't-care
		write_reg(REG_UNPAD_MODE, {5'($urandom_range(0, 31)), mode});
		write_reg(REG_BLOCK_LENGTH, len);
	endtask

	task automatic pad_frame(int len);
		logic [7:0] q[$];
		int n;
		n = $urandom_range(0, 2 * len);
		repeat (n) q.push_back(8'($urandom_range(0, 255)));
		send_frame(q, 1'b1);
	endtask

	task automatic unpad_frame(int len);
		logic [7:0] q[$];
		int nb, p, kind, n;
		nb = $urandom_range(1, (len > 8) ? 1 : 3);
		p = $urandom_range(1, len);
		repeat (nb * len - p) q.push_back(8'($urandom_range(0, 255)));
		repeat (p) q.push_back(p[7:0]);
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			// well formed
		end else if (kind < 73) begin
			q[q.size() - 1] = 8'($urandom_range(0, 255));
		end else if (kind < 81) begin
			if (p > 1)
				q[$urandom_range(q.size() - p, q.size() - 2)] ^= 8'($urandom_range(1, 255));
		end else if (kind < 89) begin
			void'(q.pop_back());
		end else if (kind < 93) begin
			q.delete();
		end else begin
			q.delete();
			n = $urandom_range(0, 2 * len);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
		end
		send_frame(q, 1'b1);
	endtask

	initial begin
		int start, len, nframes, k, phase;
		bit mode;
		logic [5:0] len_val;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// pad mode, block length 8: extremes of the byte, then an empty stream
		set_config(1'b0, 6'd8);
		send_frame('{8'h00, 8'hFF}, 1'b1);
		send_word(8'h5A, 1'b1);

		// unpad mode, block length 2
		set_config(1'b1, 6'd2);
		send_word(8'hC3, 1'b1);                      // empty stream
		send_frame('{8'hA5, 8'h01}, 1'b1);           // good pad
		send_frame('{8'h02, 8'h02}, 1'b1);           // block is all pad
		send_frame('{8'h11, 8'h00}, 1'b1);           // zero pad byte
		send_frame('{8'h22, 8'h80}, 1'b1);           // pad byte above 127
		send_frame('{8'h07, 8'h02}, 1'b1);           // pad bytes differ
		send_frame('{8'h33}, 1'b1);                  // short last block
		send_frame('{8'hFF, 8'h00, 8'h12, 8'h01}, 1'b1); // held block released

		start = sent;
		phase = 0;
		while (sent - start < RANDOM_ITEMS) begin
			case (phase)
			0: begin mode = 1'b1; len_val = 6'd32; end
			1: begin mode = 1'b0; len_val = 6'd32; end
			2: begin mode = 1'b1; len_val = 6'd0; end
			3: begin mode = 1'b0; len_val = 6'd63; end
			4: begin mode = 1'b1; len_val = 6'd33; end
			5: begin mode = 1'b0; len_val = 6'd1; end
			6: begin mode = 1'b1; len_val = 6'd1; end
			default: begin
				mode = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 3) == 0)
					len_val = 6'($urandom_range(0, 63));
				else
					len_val = 6'($urandom_range(1, 8));
			end
			endcase
			set_config(mode, len_val);
			calm = ($urandom_range(0, 3) == 0);
			len = sb.blk_len();
			nframes = $urandom_range(1, (len > 8) ? 2 : 4);
			for (k = 0; k < nframes; k++) begin
				if (mode)
					unpad_frame(len);
				else
					pad_frame(len);
			end
			// sometimes leave a stream open; the next register write restarts it
			if ($urandom_range(0, 9) < 3) begin
				repeat ($urandom_range(1, len))
					send_word(8'($urandom_range(0, 255)), 1'b0);
			end
			phase++;
		end

		s_tvalid = 1'b0;
		calm = 1'b0;
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
